### rtl/assert_macros.svh
// Assertion macros shared by the meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/lbpm_pkg.sv
`timescale 1ns / 1ps
package lbpm_pkg;

    localparam int BANDS = 20;
    localparam int LEVELS = 30;

    localparam int MAG_W = 26;
    localparam int POW_W = 52;
    localparam int BAND_W = 5;
    localparam int COUNT_W = 9;
    localparam int LVL_W = 12;
    localparam int BAR_W = 5;
    localparam int DECAY_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 40;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;

    localparam int CHUNK_W = 8;
    localparam int CHUNKS = 7;
    localparam int CHUNK_IDX_W = 3;
    localparam int CHUNK_POS_W = 3;
    localparam int PAD_W = CHUNKS * CHUNK_W - POW_W;
    localparam int EXP_W = CHUNK_IDX_W + CHUNK_POS_W;
    localparam int F6_W = 6;
    localparam int FRAC_W = 14;
    localparam int ACC_W = 20;
    localparam int ACC_SHIFT = 8;

    localparam logic [FRAC_W-1:0] LOG_K = 14'd12330;
    localparam logic [ACC_W-1:0] LOG_BIAS = 20'd154510;
    localparam logic signed [LVL_W:0] LVL_OFFSET = 13'sd2048;
    localparam logic signed [LVL_W:0] PEAK_MAX = 13'sd1023;

    localparam int BAR_X_W = 17;
    localparam int BAR_Y_W = 9;
    localparam int BAR_Q_W = 7;
    localparam int BAR_SHIFT = 7;
    localparam int RECIP_SHIFT = 10;
    localparam logic signed [BAR_X_W-1:0] BAR_GAIN = 17'sd30;
    localparam logic signed [BAR_X_W-1:0] BAR_HALF = 17'sd320;
    localparam logic [7:0] BAR_RECIP = 8'd205;
    localparam logic [BAR_Q_W-1:0] BAR_MAX = 7'd30;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 8'd40;
    localparam logic signed [LVL_W-1:0] FLOOR_RESET = -12'sd2048;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DECAY_STEP  = 2'd0,
        REG_FLOOR_LEVEL = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [DECAY_W-1:0]       decay_step;
        logic signed [LVL_W-1:0]  floor_level;
    } cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0]  re_mag;
        logic [MAG_W-1:0]  im_mag;
        logic [BAND_W-1:0] band;
        logic              close;
        logic              last;
    } bin_item_t;

    typedef struct packed {
        logic [POW_W-1:0]  power;
        logic [BAND_W-1:0] band;
    } band_max_t;

    // Exclusive end bin of each band.
    function automatic logic [COUNT_W-1:0] band_end(input logic [BAND_W-1:0] b);
        logic [COUNT_W-1:0] v;
        case (b)
            5'd0:    v = 9'd1;
            5'd1:    v = 9'd2;
            5'd2:    v = 9'd3;
            5'd3:    v = 9'd4;
            5'd4:    v = 9'd5;
            5'd5:    v = 9'd6;
            5'd6:    v = 9'd7;
            5'd7:    v = 9'd8;
            5'd8:    v = 9'd10;
            5'd9:    v = 9'd13;
            5'd10:   v = 9'd18;
            5'd11:   v = 9'd24;
            5'd12:   v = 9'd33;
            5'd13:   v = 9'd44;
            5'd14:   v = 9'd59;
            5'd15:   v = 9'd79;
            5'd16:   v = 9'd106;
            5'd17:   v = 9'd142;
            5'd18:   v = 9'd191;
            default: v = 9'd256;
        endcase
        return v;
    endfunction

    // 40960 * log10(1 + k/32), rounded.
    function automatic logic [FRAC_W-1:0] frac_db(input logic [F6_W-1:0] k);
        logic [FRAC_W-1:0] v;
        case (k)
            6'd0:    v = 14'd0;
            6'd1:    v = 14'd547;
            6'd2:    v = 14'd1078;
            6'd3:    v = 14'd1594;
            6'd4:    v = 14'd2095;
            6'd5:    v = 14'd2583;
            6'd6:    v = 14'd3057;
            6'd7:    v = 14'd3519;
            6'd8:    v = 14'd3969;
            6'd9:    v = 14'd4409;
            6'd10:   v = 14'd4837;
            6'd11:   v = 14'd5256;
            6'd12:   v = 14'd5665;
            6'd13:   v = 14'd6065;
            6'd14:   v = 14'd6456;
            6'd15:   v = 14'd6838;
            6'd16:   v = 14'd7213;
            6'd17:   v = 14'd7579;
            6'd18:   v = 14'd7939;
            6'd19:   v = 14'd8291;
            6'd20:   v = 14'd8637;
            6'd21:   v = 14'd8975;
            6'd22:   v = 14'd9308;
            6'd23:   v = 14'd9634;
            6'd24:   v = 14'd9955;
            6'd25:   v = 14'd10270;
            6'd26:   v = 14'd10579;
            6'd27:   v = 14'd10883;
            6'd28:   v = 14'd11182;
            6'd29:   v = 14'd11476;
            6'd30:   v = 14'd11765;
            6'd31:   v = 14'd12050;
            default: v = 14'd12330;
        endcase
        return v;
    endfunction

endpackage

### rtl/lbpm_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbpm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [lbpm_pkg::MAG_W-1:0]        bin_real,
    input  logic [lbpm_pkg::MAG_W-1:0]        bin_imag,
    input  logic                              last_bin,
    output logic                              push,
    output lbpm_pkg::bin_item_t               item
);

    logic [lbpm_pkg::COUNT_W-1:0] bin_count_reg;
    logic [lbpm_pkg::COUNT_W-1:0] bin_count_next;
    logic [lbpm_pkg::BAND_W-1:0]  band_reg;
    logic [lbpm_pkg::BAND_W-1:0]  band_next;
    logic [lbpm_pkg::COUNT_W-1:0] count_inc;
    logic                         in_range;
    logic                         close;

    always_comb
    begin
        in_range  = band_reg < lbpm_pkg::BAND_W'(lbpm_pkg::BANDS);
        count_inc = bin_count_reg + 1'b1;
        close     = in_range && (count_inc >= lbpm_pkg::band_end(band_reg));

        item.re_mag = bin_real[lbpm_pkg::MAG_W-1] ? (~bin_real) + 1'b1 : bin_real;
        if (bin_count_reg == '0)
        begin
            item.im_mag = '0;
        end
        else
        begin
            item.im_mag = bin_imag[lbpm_pkg::MAG_W-1] ? (~bin_imag) + 1'b1 : bin_imag;
        end
        item.band  = band_reg;
        item.close = close;
        item.last  = last_bin;
        push       = accept && in_range;

        bin_count_next = bin_count_reg;
        band_next      = band_reg;
        if (accept)
        begin
            if (in_range)
            begin
                bin_count_next = count_inc;
                if (close)
                begin
                    band_next = band_reg + 1'b1;
                end
            end
            if (last_bin)
            begin
                bin_count_next = '0;
                band_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= '0;
            band_reg      <= '0;
        end
        else
        begin
            bin_count_reg <= bin_count_next;
            band_reg      <= band_next;
        end
    end

    `ASSERT_HOLDS(a_count_bound, clk, rst_n,
        bin_count_reg <= lbpm_pkg::band_end(lbpm_pkg::BAND_W'(lbpm_pkg::BANDS - 1)))

endmodule

### rtl/lbpm_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbpm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lbpm_pkg::bin_item_t push_item,
    output logic                ready,
    input  logic                pop,
    output logic                valid,
    output lbpm_pkg::bin_item_t head
);

    lbpm_pkg::bin_item_t          mem_reg [lbpm_pkg::QUEUE_DEPTH];
    logic [lbpm_pkg::QPTR_W-1:0]  wr_reg;
    logic [lbpm_pkg::QPTR_W-1:0]  rd_reg;
    logic [lbpm_pkg::QPTR_W:0]    count_reg;

    assign ready = count_reg != (lbpm_pkg::QPTR_W + 1)'(lbpm_pkg::QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEXT(a_fill_grows, clk, rst_n, push && !pop,
        count_reg == $past(count_reg) + 1'b1)

endmodule

### rtl/lbpm_power.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbpm_power (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                q_valid,
    input  lbpm_pkg::bin_item_t q_item,
    output logic                pop,
    output logic                max_valid,
    output lbpm_pkg::band_max_t max_out
);

    logic                          s1_valid_reg;
    logic [lbpm_pkg::POW_W-1:0]    sq_re_reg;
    logic [lbpm_pkg::POW_W-1:0]    sq_im_reg;
    logic [lbpm_pkg::BAND_W-1:0]   s1_band_reg;
    logic                          s1_close_reg;
    logic                          s1_last_reg;
    logic [lbpm_pkg::POW_W-1:0]    sq_re;
    logic [lbpm_pkg::POW_W-1:0]    sq_im;
    logic [lbpm_pkg::POW_W-1:0]    sum;
    logic [lbpm_pkg::POW_W-1:0]    max_cand;
    logic [lbpm_pkg::POW_W-1:0]    max_reg;
    logic                          s2_valid_reg;
    lbpm_pkg::band_max_t           s2_reg;

    assign pop      = adv && q_valid;
    assign sq_re    = lbpm_pkg::POW_W'(q_item.re_mag) * lbpm_pkg::POW_W'(q_item.re_mag);
    assign sq_im    = lbpm_pkg::POW_W'(q_item.im_mag) * lbpm_pkg::POW_W'(q_item.im_mag);
    assign sum      = sq_re_reg + sq_im_reg;
    assign max_cand = (sum > max_reg) ? sum : max_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_re_reg      <= sq_re;
            sq_im_reg      <= sq_im;
            s1_band_reg    <= q_item.band;
            s1_close_reg   <= q_item.close;
            s1_last_reg    <= q_item.last;
            s2_reg.power   <= max_cand;
            s2_reg.band    <= s1_band_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            max_reg      <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg && s1_close_reg;
            if (s1_valid_reg)
            begin
                max_reg <= (s1_close_reg || s1_last_reg) ? '0 : max_cand;
            end
        end
    end

    assign max_valid = s2_valid_reg;
    assign max_out   = s2_reg;

    `ASSERT_NEXT(a_max_cleared, clk, rst_n,
        adv && s1_valid_reg && (s1_close_reg || s1_last_reg), max_reg == '0)

endmodule

### rtl/lbpm_level.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbpm_level (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lbpm_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    input  lbpm_pkg::band_max_t                 in_max,
    input  logic                                out_ready,
    output logic                                adv,
    output logic                                out_valid,
    output logic [lbpm_pkg::BAND_W-1:0]         band_index,
    output logic signed [lbpm_pkg::LVL_W-1:0]   peak_level,
    output logic signed [lbpm_pkg::LVL_W-1:0]   held_level,
    output logic [lbpm_pkg::BAR_W-1:0]          bar_level,
    output logic                                last_band
);

    localparam int LW = lbpm_pkg::LVL_W;

    // Leading-one search, first half: one priority encoder per byte.
    logic [lbpm_pkg::CHUNKS*lbpm_pkg::CHUNK_W-1:0] padded;
    logic [lbpm_pkg::CHUNKS-1:0]                   nz;
    logic [lbpm_pkg::CHUNK_POS_W-1:0]              pos [lbpm_pkg::CHUNKS];
    logic                                          l1_valid_reg;
    logic [lbpm_pkg::POW_W-1:0]                    l1_power_reg;
    logic [lbpm_pkg::CHUNKS-1:0]                   l1_nz_reg;
    logic [lbpm_pkg::CHUNK_POS_W-1:0]              l1_pos_reg [lbpm_pkg::CHUNKS];
    logic [lbpm_pkg::BAND_W-1:0]                   l1_band_reg;

    logic [lbpm_pkg::EXP_W-1:0]                    e;
    logic [lbpm_pkg::POW_W+lbpm_pkg::F6_W-1:0]     shifted;
    logic                                          l2_valid_reg;
    logic [lbpm_pkg::EXP_W-1:0]                    l2_e_reg;
    logic [lbpm_pkg::F6_W-1:0]                     l2_f6_reg;
    logic                                          l2_zero_reg;
    logic [lbpm_pkg::BAND_W-1:0]                   l2_band_reg;

    logic [lbpm_pkg::F6_W:0]                       f6_inc;
    logic [lbpm_pkg::ACC_W-1:0]                    acc;
    logic signed [LW:0]                            lvl;
    logic signed [LW:0]                            floor_ext;
    logic signed [LW:0]                            pk;
    logic                                          l3_valid_reg;
    logic signed [LW-1:0]                          l3_peak_reg;
    logic [lbpm_pkg::BAND_W-1:0]                   l3_band_reg;

    logic signed [LW-1:0]                          held_reg [lbpm_pkg::BANDS];
    logic signed [LW-1:0]                          held_old;
    logic signed [LW:0]                            dec;
    logic signed [LW-1:0]                          held_new;
    logic                                          h_valid_reg;
    logic signed [LW-1:0]                          h_peak_reg;
    logic signed [LW-1:0]                          h_held_reg;
    logic [lbpm_pkg::BAND_W-1:0]                   h_band_reg;

    logic signed [lbpm_pkg::BAR_X_W-1:0]           bar_x;
    logic [lbpm_pkg::BAR_Y_W-1:0]                  bar_y;
    logic [lbpm_pkg::BAR_Y_W+7:0]                  bar_prod;
    logic [lbpm_pkg::BAR_Q_W-1:0]                  bar_q;
    logic [lbpm_pkg::BAR_W-1:0]                    bar;
    logic                                          out_valid_reg;
    logic [lbpm_pkg::BAND_W-1:0]                   out_band_reg;
    logic signed [LW-1:0]                          out_peak_reg;
    logic signed [LW-1:0]                          out_held_reg;
    logic [lbpm_pkg::BAR_W-1:0]                    out_bar_reg;

    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        padded = {{lbpm_pkg::PAD_W{1'b0}}, in_max.power};
        for (int c = 0; c < lbpm_pkg::CHUNKS; c++)
        begin
            nz[c]  = |padded[c*lbpm_pkg::CHUNK_W +: lbpm_pkg::CHUNK_W];
            pos[c] = '0;
            for (int b = 0; b < lbpm_pkg::CHUNK_W; b++)
            begin
                if (padded[c*lbpm_pkg::CHUNK_W + b])
                begin
                    pos[c] = lbpm_pkg::CHUNK_POS_W'(b);
                end
            end
        end
    end

    always_comb
    begin
        e = '0;
        for (int c = 0; c < lbpm_pkg::CHUNKS; c++)
        begin
            if (l1_nz_reg[c])
            begin
                e = {lbpm_pkg::CHUNK_IDX_W'(c), l1_pos_reg[c]};
            end
        end
        shifted = {l1_power_reg, {lbpm_pkg::F6_W{1'b0}}} >> e;
    end

    always_comb
    begin
        f6_inc = {1'b0, l2_f6_reg} + 1'b1;
        acc = lbpm_pkg::ACC_W'(l2_e_reg) * lbpm_pkg::ACC_W'(lbpm_pkg::LOG_K)
            + lbpm_pkg::ACC_W'(lbpm_pkg::frac_db(f6_inc[lbpm_pkg::F6_W:1]))
            + lbpm_pkg::LOG_BIAS;
        lvl = $signed({1'b0, acc[lbpm_pkg::ACC_W-1:lbpm_pkg::ACC_SHIFT]})
            - lbpm_pkg::LVL_OFFSET;
        floor_ext = {cfg.floor_level[LW-1], cfg.floor_level};
        if (l2_zero_reg || (lvl < floor_ext))
        begin
            pk = floor_ext;
        end
        else
        begin
            pk = lvl;
        end
        if (pk > lbpm_pkg::PEAK_MAX)
        begin
            pk = lbpm_pkg::PEAK_MAX;
        end
    end

    always_comb
    begin
        held_old = held_reg[l3_band_reg];
        dec = {held_old[LW-1], held_old} - $signed({5'b0, cfg.decay_step});
        if (l3_peak_reg < held_old)
        begin
            if (dec < $signed({l3_peak_reg[LW-1], l3_peak_reg}))
            begin
                held_new = l3_peak_reg;
            end
            else
            begin
                held_new = dec[LW-1:0];
            end
        end
        else
        begin
            held_new = l3_peak_reg;
        end
    end

    always_comb
    begin
        bar_x = {{(lbpm_pkg::BAR_X_W - LW){h_held_reg[LW-1]}}, h_held_reg}
            * lbpm_pkg::BAR_GAIN + lbpm_pkg::BAR_HALF;
        bar_y = bar_x[lbpm_pkg::BAR_X_W-2:lbpm_pkg::BAR_SHIFT];
        bar_prod = (lbpm_pkg::BAR_Y_W+8)'(bar_y) * (lbpm_pkg::BAR_Y_W+8)'(lbpm_pkg::BAR_RECIP);
        bar_q = bar_prod[lbpm_pkg::BAR_Y_W+7:lbpm_pkg::RECIP_SHIFT];
        if (bar_x <= 0)
        begin
            bar = '0;
        end
        else if (bar_q > lbpm_pkg::BAR_MAX)
        begin
            bar = lbpm_pkg::BAR_W'(lbpm_pkg::BAR_MAX);
        end
        else
        begin
            bar = bar_q[lbpm_pkg::BAR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_power_reg <= in_max.power;
            l1_nz_reg    <= nz;
            l1_pos_reg   <= pos;
            l1_band_reg  <= in_max.band;
            l2_e_reg     <= e;
            l2_f6_reg    <= shifted[lbpm_pkg::F6_W-1:0];
            l2_zero_reg  <= ~|l1_nz_reg;
            l2_band_reg  <= l1_band_reg;
            l3_peak_reg  <= pk[LW-1:0];
            l3_band_reg  <= l2_band_reg;
            h_peak_reg   <= l3_peak_reg;
            h_held_reg   <= held_new;
            h_band_reg   <= l3_band_reg;
            out_band_reg <= h_band_reg;
            out_peak_reg <= h_peak_reg;
            out_held_reg <= h_held_reg;
            out_bar_reg  <= bar;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg  <= 1'b0;
            l2_valid_reg  <= 1'b0;
            l3_valid_reg  <= 1'b0;
            h_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < lbpm_pkg::BANDS; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            l1_valid_reg  <= in_valid;
            l2_valid_reg  <= l1_valid_reg;
            l3_valid_reg  <= l2_valid_reg;
            h_valid_reg   <= l3_valid_reg;
            out_valid_reg <= h_valid_reg;
            if (l3_valid_reg)
            begin
                held_reg[l3_band_reg] <= held_new;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign band_index = out_band_reg;
    assign peak_level = out_peak_reg;
    assign held_level = out_held_reg;
    assign bar_level  = out_bar_reg;
    assign last_band  = out_band_reg == lbpm_pkg::BAND_W'(lbpm_pkg::BANDS - 1);

    `ASSERT_HOLDS(a_held_not_below_peak, clk, rst_n,
        !out_valid_reg || (out_held_reg >= out_peak_reg))
    `ASSERT_HOLDS(a_bar_bound, clk, rst_n,
        !out_valid_reg || (out_bar_reg <= lbpm_pkg::BAR_W'(lbpm_pkg::LEVELS)))

endmodule

### rtl/log_band_peak_meter_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat                        Payload
// s_*      in   one FFT bin                 tdata: bin_real, bin_imag; tlast: last_bin
// m_*      out  one closed band             tdata: band_index, peak_level, held_level,
//                                           bar_level; tlast: last_band
// cfg_*    in   one register write          cfg_index, cfg_data
//
// One bin is accepted per cycle while the bin queue is not full; s_tready depends only on the four-entry bin queue.
// A band result passes the bin queue, the power registers s1 and s2 and the level registers l1, l2, l3, h and out.
// A stall on m_tready freezes the back pipeline; the queue then fills and drops s_tready.
// Reset clears counts, the running maximum and all held levels, and loads both
// registers with their default values.
module log_band_peak_meter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // bin_real [25:0], bin_imag [51:26], zero pad [55:52]
    input  logic [lbpm_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // band_index [4:0], peak_level [16:5], held_level [28:17], bar_level [33:29], zero [39:34]
    output logic [lbpm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lbpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lbpm_pkg::LVL_W-1:0]          cfg_data
);

    lbpm_pkg::cfg_t                         cfg_reg;
    lbpm_pkg::bin_item_t                    front_item;
    lbpm_pkg::bin_item_t                    q_head;
    lbpm_pkg::band_max_t                    band_max;
    logic                                   push;
    logic                                   q_ready;
    logic                                   q_valid;
    logic                                   pop;
    logic                                   adv;
    logic                                   max_valid;
    logic [lbpm_pkg::BAND_W-1:0]            band_index;
    logic signed [lbpm_pkg::LVL_W-1:0]      peak_level;
    logic signed [lbpm_pkg::LVL_W-1:0]      held_level;
    logic [lbpm_pkg::BAR_W-1:0]             bar_level;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decay_step  <= lbpm_pkg::DECAY_RESET;
            cfg_reg.floor_level <= lbpm_pkg::FLOOR_RESET;
        end
        else if (cfg_valid)
        begin
            case (lbpm_pkg::cfg_reg_t'(cfg_index))
                lbpm_pkg::REG_DECAY_STEP:  cfg_reg.decay_step  <= cfg_data[lbpm_pkg::DECAY_W-1:0];
                lbpm_pkg::REG_FLOOR_LEVEL: cfg_reg.floor_level <= cfg_data;
                default: ;
            endcase
        end
    end

    lbpm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (s_tvalid && q_ready),
        .bin_real (s_tdata[lbpm_pkg::MAG_W-1:0]),
        .bin_imag (s_tdata[2*lbpm_pkg::MAG_W-1:lbpm_pkg::MAG_W]),
        .last_bin (s_tlast),
        .push     (push),
        .item     (front_item)
    );

    lbpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .ready     (q_ready),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    lbpm_power u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .pop       (pop),
        .max_valid (max_valid),
        .max_out   (band_max)
    );

    lbpm_level u_level (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (max_valid),
        .in_max     (band_max),
        .out_ready  (m_tready),
        .adv        (adv),
        .out_valid  (m_tvalid),
        .band_index (band_index),
        .peak_level (peak_level),
        .held_level (held_level),
        .bar_level  (bar_level),
        .last_band  (m_tlast)
    );

    assign m_tdata = {6'b0, bar_level, held_level, peak_level, band_index};

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int MAG_W = lbpm_pkg::MAG_W;
    localparam int POW_W = lbpm_pkg::POW_W;
    localparam int BAND_TOTAL = 20;
    localparam int BAR_TOP = 30;
    localparam int LOG2_STEP = 12330;
    localparam int LEVEL_BIAS = 154510;
    localparam int LEVEL_OFFSET = 2048;
    localparam int PEAK_CEILING = 1023;
    localparam int BAR_STEP = 640;
    localparam int BAR_ROUND = 320;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [lbpm_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [lbpm_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic signed [MAG_W-1:0] PART_MIN = {1'b1, {(MAG_W - 1){1'b0}}};
    localparam logic signed [MAG_W-1:0] PART_MAX = {1'b0, {(MAG_W - 1){1'b1}}};

    typedef struct {
        logic signed [MAG_W-1:0] re;
        logic signed [MAG_W-1:0] im;
        logic last;
    } fft_bin_t;

    typedef struct {
        int band;
        int peak;
        int held;
        int bar;
        bit last_band;
    } band_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [lbpm_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [lbpm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [lbpm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lbpm_pkg::LVL_W-1:0] cfg_data = '0;

    int band_stop [BAND_TOTAL] = '{1, 2, 3, 4, 5, 6, 7, 8, 10, 13, 18, 24, 33, 44, 59, 79, 106,
                                   142, 191, 256};
    int log_frac [33] = '{0, 547, 1078, 1594, 2095, 2583, 3057, 3519, 3969, 4409, 4837, 5256,
                          5665, 6065, 6456, 6838, 7213, 7579, 7939, 8291, 8637, 8975, 9308,
                          9634, 9955, 10270, 10579, 10883, 11182, 11476, 11765, 12050, 12330};

    int decay_db;
    int floor_db;
    int bins_seen;
    int band_at;
    logic [POW_W-1:0] band_max;
    int held_db [BAND_TOTAL];

    fft_bin_t pending_bins [$];
    band_report_t band_reports [$];
    fft_bin_t cur_bin;
    int gap_left = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    int errors = 0;
    int bins_sent = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int settings_used = 1;

    log_band_peak_meter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int db_level(input logic [POW_W-1:0] pwr);
        int msb;
        logic [5:0] frac6;
        int slot;
        int sum;
        msb = 0;
        for (int b = 0; b < POW_W; b++)
            if (pwr[b])
                msb = b;
        if (msb >= 6)
            frac6 = 6'(pwr >> (msb - 6));
        else
            frac6 = 6'(pwr << (6 - msb));
        slot = (int'(frac6) + 1) >> 1;
        sum = msb * LOG2_STEP + log_frac[slot] + LEVEL_BIAS;
        return (sum >>> 8) - LEVEL_OFFSET;
    endfunction

    function automatic bit meter_update(input fft_bin_t b, output band_report_t r);
        logic [MAG_W-1:0] mag_re;
        logic [MAG_W-1:0] mag_im;
        logic [POW_W-1:0] pwr;
        int peak;
        int held;
        int x;
        int bar;
        bit closed;
        closed = 1'b0;
        r = '{default: 0};
        if (band_at < BAND_TOTAL)
        begin
            mag_re = b.re[MAG_W-1] ? -b.re : b.re;
            mag_im = b.im[MAG_W-1] ? -b.im : b.im;
            pwr = POW_W'(mag_re) * POW_W'(mag_re);
            if (bins_seen != 0)
                pwr = pwr + POW_W'(mag_im) * POW_W'(mag_im);
            if (pwr > band_max)
                band_max = pwr;
            bins_seen++;
            if (bins_seen >= band_stop[band_at])
            begin
                peak = (band_max == 0) ? floor_db : db_level(band_max);
                if (peak < floor_db)
                    peak = floor_db;
                if (peak > PEAK_CEILING)
                    peak = PEAK_CEILING;
                held = held_db[band_at];
                if (peak < held)
                begin
                    held = held - decay_db;
                    if (held < peak)
                        held = peak;
                end
                else
                    held = peak;
                held_db[band_at] = held;
                x = held * BAR_TOP + BAR_ROUND;
                bar = (x <= 0) ? 0 : x / BAR_STEP;
                if (bar > BAR_TOP)
                    bar = BAR_TOP;
                r.band = band_at;
                r.peak = peak;
                r.held = held;
                r.bar = bar;
                r.last_band = (band_at == BAND_TOTAL - 1);
                closed = 1'b1;
                band_max = '0;
                band_at++;
            end
        end
        if (b.last)
        begin
            bins_seen = 0;
            band_at = 0;
            band_max = '0;
        end
        return closed;
    endfunction

    function automatic fft_bin_t make_bin(input logic signed [MAG_W-1:0] re,
                                          input logic signed [MAG_W-1:0] im, input logic last);
        fft_bin_t b;
        b.re = re;
        b.im = im;
        b.last = last;
        return b;
    endfunction

    function automatic logic signed [MAG_W-1:0] rand_part(input int shift);
        logic signed [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return PART_MIN;
            2: return PART_MAX;
            default: return MAG_W'(raw >>> shift);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [lbpm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lbpm_pkg::LVL_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lbpm_pkg::REG_DECAY_STEP: decay_db = data[7:0];
            lbpm_pkg::REG_FLOOR_LEVEL: floor_db = $signed(data);
            default: ;
        endcase
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (pending_bins.size() != 0 || s_tvalid || band_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_random_bins(input int budget, input bit with_full);
        int added;
        int len;
        int shift;
        bit full;
        added = 0;
        full = with_full;
        while (added < budget || full)
        begin
            shift = $urandom_range(0, 31);
            if (full)
                len = $urandom_range(256, 290);
            else if ($urandom_range(0, 7) == 0)
                len = 1;
            else
                len = $urandom_range(2, 60);
            for (int k = 0; k < len; k++)
                pending_bins.push_back(make_bin(rand_part(shift), rand_part(shift),
                                                k == len - 1));
            if (!full)
                added += len;
            full = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : feed_bins
        band_report_t rep;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                bins_sent++;
                if (cur_bin.last)
                    frames_sent++;
                if (meter_update(cur_bin, rep))
                    band_reports.push_back(rep);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bins.size() > 0)
                begin
                    cur_bin = pending_bins.pop_front();
                    s_tdata <= {{(lbpm_pkg::IN_DATA_W - 2 * MAG_W){1'b0}}, cur_bin.im, cur_bin.re};
                    s_tlast <= cur_bin.last;
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(1, 15);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : watch_bands
        band_report_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (band_reports.size() == 0)
                    report_mismatch("unexpected band result, band_index", m_tdata[4:0], -1);
                else
                begin
                    want = band_reports.pop_front();
                    results_seen++;
                    if (m_tdata[4:0] != want.band)
                        report_mismatch("band_index", m_tdata[4:0], want.band);
                    if ($signed(m_tdata[16:5]) != want.peak)
                        report_mismatch("peak_level", $signed(m_tdata[16:5]), want.peak);
                    if ($signed(m_tdata[28:17]) != want.held)
                        report_mismatch("held_level", $signed(m_tdata[28:17]), want.held);
                    if (m_tdata[33:29] != want.bar)
                        report_mismatch("bar_level", m_tdata[33:29], want.bar);
                    if (m_tlast != want.last_band)
                        report_mismatch("last_band", m_tlast, want.last_band);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        decay_db = 40;
        floor_db = -2048;
        bins_seen = 0;
        band_at = 0;
        band_max = '0;
        foreach (held_db[i])
            held_db[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes of both parts, tiny powers, and a frame that closes mid-table.
        pending_bins.push_back(make_bin(PART_MIN, PART_MAX, 1'b0));
        pending_bins.push_back(make_bin(PART_MIN, PART_MIN, 1'b0));
        pending_bins.push_back(make_bin('0, '0, 1'b0));
        pending_bins.push_back(make_bin(MAG_W'(1), '0, 1'b0));
        pending_bins.push_back(make_bin(PART_MAX, PART_MAX, 1'b0));
        pending_bins.push_back(make_bin('0, '0, 1'b0));
        pending_bins.push_back(make_bin('0, MAG_W'(-1), 1'b0));
        pending_bins.push_back(make_bin(PART_MIN, '0, 1'b0));
        pending_bins.push_back(make_bin(MAG_W'(-1), MAG_W'(1), 1'b0));
        pending_bins.push_back(make_bin('0, PART_MIN, 1'b1));
        // A silent short frame lets the held levels decay and drops an open band.
        for (int k = 0; k < 12; k++)
            pending_bins.push_back(make_bin('0, '0, k == 11));
        pending_bins.push_back(make_bin(PART_MAX, PART_MIN, 1'b1));
        settle();

        write_reg(lbpm_pkg::REG_DECAY_STEP, 12'($urandom_range(0, 15)) << 8);
        write_reg(lbpm_pkg::REG_FLOOR_LEVEL, -12'sd2048);
        settings_used++;
        add_random_bins(30, 1'b0);
        settle();

        write_reg(lbpm_pkg::REG_DECAY_STEP, 12'd255);
        write_reg(lbpm_pkg::REG_FLOOR_LEVEL, 12'd0);
        settings_used++;
        add_random_bins(30, 1'b1);
        settle();

        write_reg(REG_SPARE_2, 12'($urandom()));
        write_reg(REG_SPARE_3, 12'($urandom()));
        write_reg(lbpm_pkg::REG_DECAY_STEP, 12'($urandom()));
        write_reg(lbpm_pkg::REG_FLOOR_LEVEL, 12'd2047);
        settings_used++;
        add_random_bins(30, 1'b0);
        settle();

        write_reg(lbpm_pkg::REG_DECAY_STEP, 12'($urandom_range(1, 254)));
        write_reg(lbpm_pkg::REG_FLOOR_LEVEL, 12'(-$urandom_range(1, 2048)));
        settings_used++;
        add_random_bins(30, 1'b0);
        settle();

        quiet = 1'b1;
        write_reg(lbpm_pkg::REG_DECAY_STEP, 12'd40);
        write_reg(lbpm_pkg::REG_FLOOR_LEVEL, 12'(-$urandom_range(0, 2048)));
        settings_used++;
        add_random_bins(30, 1'b0);
        settle();

        $display("tb_top summary: %0d bins in %0d frames under %0d register settings",
                 bins_sent, frames_sent, settings_used);
        $display("tb_top summary: %0d band results compared, %0d mismatches",
                 results_seen, errors);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/lbpm_pkg.sv
rtl/lbpm_front.sv
rtl/lbpm_queue.sv
rtl/lbpm_power.sv
rtl/lbpm_level.sv
rtl/log_band_peak_meter_top.sv
sim/tb_top.sv
